// File: rtl/scc_pkg.sv
// Shared types and constants for the sensor calibration converter.
package scc_pkg;

   typedef enum logic [1:0] {
      CMD_DEPTH      = 2'd0,
      CMD_THERMISTOR = 2'd1,
      CMD_CONDUCT    = 2'd2,
      CMD_UNUSED     = 2'd3
   } cmd_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_NONPOS  = 2'd2;

   localparam logic [2:0] REG_DEPTH_OFFSET = 3'd0;
   localparam logic [2:0] REG_DEPTH_GAIN   = 3'd1;
   localparam logic [2:0] REG_SUPPLY       = 3'd2;
   localparam logic [2:0] REG_GROUND       = 3'd3;
   localparam logic [2:0] REG_THERM_REF    = 3'd4;
   localparam logic [2:0] REG_CELL_DIV     = 3'd5;
   localparam logic [2:0] REG_CELL_SERIES  = 3'd6;

   // conductance numerators: scale * 1000000
   localparam logic [25:0] COND_NUM_32 = 26'd32000000;
   localparam logic [25:0] COND_NUM_64 = 26'd64000000;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] raw_sample;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } rsp_type;

   // sideband through the first divider
   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] depth;
      logic        neg;
      logic        zero_den;
      logic        big;
   } side1_type;

   // sideband through the second divider
   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] val16;
      logic [1:0]  status;
   } side2_type;

endpackage

// File: rtl/scc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module scc_div #(
   parameter int NumW  = 40,
   parameter int DenW  = 17,
   parameter int SideW = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NumW-1:0]  in_num,
   input  logic [DenW-1:0]  in_den,
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   output logic [NumW-1:0]  out_quo,
   output logic [SideW-1:0] out_side
);

   logic             vld_ff  [NumW];
   logic [DenW-1:0]  rem_ff  [NumW];
   logic [NumW-1:0]  num_ff  [NumW];
   logic [NumW-1:0]  quo_ff  [NumW];
   logic [DenW-1:0]  den_ff  [NumW];
   logic [SideW-1:0] side_ff [NumW];

   for (genvar i = 0; i < NumW; i++) begin : g_stage
      logic             vld_p;
      logic [DenW-1:0]  rem_p;
      logic [NumW-1:0]  num_p;
      logic [NumW-1:0]  quo_p;
      logic [DenW-1:0]  den_p;
      logic [SideW-1:0] side_p;
      logic [DenW:0]    trial;
      logic [DenW:0]    diff;
      logic             ge;

      if (i == 0) begin : g_first
         assign vld_p  = in_valid;
         assign rem_p  = '0;
         assign num_p  = in_num;
         assign quo_p  = '0;
         assign den_p  = in_den;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[i-1];
         assign rem_p  = rem_ff[i-1];
         assign num_p  = num_ff[i-1];
         assign quo_p  = quo_ff[i-1];
         assign den_p  = den_ff[i-1];
         assign side_p = side_ff[i-1];
      end

      assign trial = {rem_p, num_p[NumW-1]};
      assign diff  = trial - {1'b0, den_p};
      assign ge    = (trial >= {1'b0, den_p});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
            num_ff[i]  <= {num_p[NumW-2:0], 1'b0};
            quo_ff[i]  <= {quo_p[NumW-2:0], ge};
            den_ff[i]  <= den_p;
            side_ff[i] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[NumW-1];
   assign out_quo   = quo_ff[NumW-1];
   assign out_side  = side_ff[NumW-1];

endmodule

// File: rtl/sensor_calibration_converter.sv
// Top level of the sensor calibration converter: depth, thermistor and conductance.
//
// A request carries a command and a signed 16-bit sample; every request
// gives exactly one response with a 32-bit value and a 2-bit status.
// Depth, thermistor resistance and cell conductance are selected by command.
// The block is a single pipeline of 72 register stages: three front stages
// (differences, products, sign handling), a 40-stage divider for the first
// quotient, two stages forming the cell resistance, a 26-stage divider for
// the conductance and the response register. One request is taken every
// cycle while the pipeline is not stalled.
// When the receiver holds rsp_ready low while a response is shown, the
// whole pipeline freezes and req_ready drops; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the
// calibration registers with their defaults. The csr_ port writes one
// register per cycle with csr_we; write it only while the pipeline is empty.
module sensor_calibration_converter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  scc_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output scc_pkg::rsp_type        rsp_data,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_wdata
);

   localparam int N1 = 40;
   localparam int D1 = 17;
   localparam int N2 = 26;
   localparam int D2 = 41;

   logic en;

   // calibration registers
   logic signed [15:0] offset_ff, gain_ff, supply_ff, ground_ff;
   logic [15:0]        tref_ff, cdiv_ff, series_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 16'sd0;
         gain_ff   <= 16'sd1024;
         supply_ff <= 16'sd32767;
         ground_ff <= 16'sd0;
         tref_ff   <= 16'd10000;
         cdiv_ff   <= 16'd10000;
         series_ff <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            scc_pkg::REG_DEPTH_OFFSET: offset_ff <= csr_wdata;
            scc_pkg::REG_DEPTH_GAIN:   gain_ff   <= csr_wdata;
            scc_pkg::REG_SUPPLY:       supply_ff <= csr_wdata;
            scc_pkg::REG_GROUND:       ground_ff <= csr_wdata;
            scc_pkg::REG_THERM_REF:    tref_ff   <= csr_wdata;
            scc_pkg::REG_CELL_DIV:     cdiv_ff   <= csr_wdata;
            scc_pkg::REG_CELL_SERIES:  series_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 1: differences
   logic               v1_ff;
   scc_pkg::cmd_type   cmd1_ff;
   logic signed [16:0] d1_ff, c1_ff, den1_ff;
   logic               big1_ff;

   // stage 2: products
   logic               v2_ff;
   scc_pkg::cmd_type   cmd2_ff;
   logic signed [32:0] pd2_ff;
   logic signed [33:0] pt2_ff, pc2_ff;
   logic signed [16:0] den2_ff;
   logic               big2_ff;

   // stage 3: depth result, divider operands
   logic                v3_ff;
   logic [N1-1:0]       num3_ff;
   logic [D1-1:0]       den3_ff;
   scc_pkg::side1_type  s3_ff;

   logic signed [33:0]  dsum;
   logic signed [39:0]  num_sel;
   logic [N1-1:0]       num_mag;
   logic [D1-1:0]       den_mag;
   scc_pkg::side1_type  s3_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_comb begin
      dsum    = 34'(pd2_ff) + (pd2_ff[32] ? 34'sd1023 : 34'sd0);
      if (cmd2_ff == scc_pkg::CMD_THERMISTOR) begin
         num_sel = 40'(pt2_ff);
      end else begin
         num_sel = big2_ff ? (40'(pc2_ff) <<< 5) : (40'(pc2_ff) <<< 6);
      end
      num_mag = num_sel[39] ? N1'(-num_sel) : N1'(num_sel);
      den_mag = den2_ff[16] ? D1'(-den2_ff) : D1'(den2_ff);
      s3_in.cmd      = cmd2_ff;
      s3_in.depth    = dsum[25:10];
      s3_in.neg      = num_sel[39] ^ den2_ff[16];
      s3_in.zero_den = (den2_ff == 17'sd0);
      s3_in.big      = big2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff <= scc_pkg::cmd_type'(req_data.command);
         d1_ff   <= 17'(req_data.raw_sample) - 17'(offset_ff);
         c1_ff   <= 17'(req_data.raw_sample) - 17'(ground_ff);
         den1_ff <= 17'(supply_ff) - 17'(req_data.raw_sample);
         big1_ff <= (req_data.raw_sample > 16'sd1000);

         cmd2_ff <= cmd1_ff;
         pd2_ff  <= 33'(d1_ff) * 33'(gain_ff);
         pt2_ff  <= 34'($signed({1'b0, tref_ff})) * 34'(c1_ff);
         pc2_ff  <= 34'($signed({1'b0, cdiv_ff})) * 34'(c1_ff);
         den2_ff <= den1_ff;
         big2_ff <= big1_ff;

         num3_ff <= num_mag;
         den3_ff <= den_mag;
         s3_ff   <= s3_in;
      end
   end

   // first divider
   logic               v_d1;
   logic [N1-1:0]      quo1;
   logic [$bits(scc_pkg::side1_type)-1:0] side1_out;

   scc_div #(
      .NumW  (N1),
      .DenW  (D1),
      .SideW ($bits(scc_pkg::side1_type))
   ) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_num    (num3_ff),
      .in_den    (den3_ff),
      .in_side   (s3_ff),
      .out_valid (v_d1),
      .out_quo   (quo1),
      .out_side  (side1_out)
   );

   scc_pkg::side1_type s_d1;
   assign s_d1 = scc_pkg::side1_type'(side1_out);

   // stage 4: signed quotient
   logic               v4_ff;
   logic signed [40:0] q4_ff;
   scc_pkg::side1_type s4_ff;

   // stage 5: cell resistance and status
   logic               v5_ff;
   logic signed [41:0] r5_ff;
   logic               big5_ff;
   scc_pkg::side2_type s5_ff;

   logic signed [41:0] r_next;
   scc_pkg::side2_type s5_in;

   always_comb begin
      r_next = 42'(q4_ff) - (s4_ff.big ? 42'({series_ff, 5'd0}) : 42'({series_ff, 6'd0}));
      s5_in.cmd    = s4_ff.cmd;
      s5_in.val16  = 16'd0;
      s5_in.status = scc_pkg::ST_OK;
      unique case (s4_ff.cmd)
         scc_pkg::CMD_DEPTH: begin
            s5_in.val16 = s4_ff.depth;
         end
         scc_pkg::CMD_THERMISTOR: begin
            if (s4_ff.zero_den) begin
               s5_in.status = scc_pkg::ST_ZERO_DEN;
            end else begin
               s5_in.val16 = q4_ff[15:0];
            end
         end
         scc_pkg::CMD_CONDUCT: begin
            if (s4_ff.zero_den) begin
               s5_in.status = scc_pkg::ST_ZERO_DEN;
            end else if (r_next <= 42'sd0) begin
               s5_in.status = scc_pkg::ST_NONPOS;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v_d1;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q4_ff   <= s_d1.neg ? -$signed({1'b0, quo1}) : $signed({1'b0, quo1});
         s4_ff   <= s_d1;
         r5_ff   <= r_next;
         big5_ff <= s4_ff.big;
         s5_ff   <= s5_in;
      end
   end

   // second divider: scale * 1000000 / r
   logic               v_d2;
   logic [N2-1:0]      quo2;
   logic [$bits(scc_pkg::side2_type)-1:0] side2_out;

   scc_div #(
      .NumW  (N2),
      .DenW  (D2),
      .SideW ($bits(scc_pkg::side2_type))
   ) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_num    (big5_ff ? scc_pkg::COND_NUM_32 : scc_pkg::COND_NUM_64),
      .in_den    (r5_ff[D2-1:0]),
      .in_side   (s5_ff),
      .out_valid (v_d2),
      .out_quo   (quo2),
      .out_side  (side2_out)
   );

   scc_pkg::side2_type s_d2;
   assign s_d2 = scc_pkg::side2_type'(side2_out);

   // response register
   logic            rsp_valid_ff;
   scc_pkg::rsp_type rsp_ff;
   scc_pkg::rsp_type rsp_in;

   always_comb begin
      rsp_in.status = s_d2.status;
      rsp_in.value  = 32'd0;
      unique case (s_d2.cmd)
         scc_pkg::CMD_DEPTH:      rsp_in.value = {{16{s_d2.val16[15]}}, s_d2.val16};
         scc_pkg::CMD_THERMISTOR: rsp_in.value = {16'd0, s_d2.val16};
         scc_pkg::CMD_CONDUCT: begin
            if (s_d2.status == scc_pkg::ST_OK) begin
               rsp_in.value = 32'(quo2);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_d2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // an error status never comes with a value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != scc_pkg::ST_OK |-> rsp_data.value == 32'd0)
      else $error("error response with nonzero value");

   // only depth can exceed the conductance ceiling, and then it is sign-extended
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.value > 32'd64000000 |-> rsp_data.value[31:16] == 16'hFFFF)
      else $error("response value out of range");

   // a stall freezes the valid bits of stages one, three and five
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(v1_ff) && $stable(v3_ff) && $stable(v5_ff))
      else $error("pipeline moved during stall");

   // a request taken while the pipeline front is free enters stage one
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted request lost");
`endif

endmodule
